### rtl/core/ffba_pkg.sv
// shared constants, codes and item types of the first-fit block allocator
package ffba_pkg;
  localparam int unsigned MAX_BLOCKS   = 64;
  localparam int unsigned WORD_BYTES   = 8;
  localparam int unsigned HEADER_BYTES = 24;
  localparam int unsigned MGMT_BYTES   = 16;
  localparam int unsigned POOL_RESET   = 4096;

  localparam int unsigned AW      = $clog2(MAX_BLOCKS);
  localparam int unsigned CW      = AW + 1;
  localparam int unsigned SIZE_W  = 16;
  localparam int unsigned ENTRY_W = SIZE_W + 1;

  localparam logic [1:0] REQ_ALLOC = 2'd0;
  localparam logic [1:0] REQ_FREE  = 2'd1;
  localparam logic [1:0] REQ_QUERY = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_FIT   = 2'd1;
  localparam logic [1:0] ST_NO_BLOCK = 2'd2;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] request_bytes;
    logic [15:0] payload_offset;
  } ffba_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] granted_offset;
    logic [15:0] largest_free;
    logic [6:0]  block_total;
  } ffba_out_t;

  typedef struct packed {
    logic              free;
    logic [SIZE_W-1:0] size;
  } ffba_entry_t;
endpackage

### rtl/core/ffba_ram.sv
// generic single-write, single-read ram with registered read data
module ffba_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule

### rtl/core/ffba_seq.sv
// table walker: merge, first-fit with split ripple, free lookup
module ffba_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [15:0]        cfg_wdata_i,
  input  logic               start_i,
  input  ffba_pkg::ffba_in_t req_i,
  input  logic               ack_i,
  output logic               idle_o,
  output logic               done_o,
  output ffba_pkg::ffba_out_t res_o
);
  import ffba_pkg::*;

  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_MERGE = 3'd2;
  localparam logic [2:0] S_ALLOC = 3'd3;
  localparam logic [2:0] S_FREE  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]        state_q, state_d;
  logic [CW-1:0]     count_q, count_d;
  logic [15:0]       pool_q, pool_d;
  ffba_in_t          req_q, req_d;
  logic [CW-1:0]     iss_q, iss_d;
  logic              vld_q, vld_d;
  logic [AW-1:0]     pidx_q, pidx_d;
  logic [CW-1:0]     wi_q, wi_d;
  ffba_entry_t       acc_q, acc_d;
  logic              acc_vld_q, acc_vld_d;
  logic [15:0]       best_q, best_d;
  logic [17:0]       start_q, start_d;
  logic [16:0]       need_q, need_d;
  ffba_entry_t       carry_q, carry_d;
  logic              shift_q, shift_d;
  logic [1:0]        status_q, status_d;
  logic [15:0]       granted_q, granted_d;
  logic [15:0]       largest_q, largest_d;

  logic              rd_en, wr_en;
  logic [AW-1:0]     rd_addr, wr_addr;
  ffba_entry_t       wr_data, rdata;
  logic [ENTRY_W-1:0] rdata_raw;
  logic              more;
  logic [15:0]       best_fin, rem;
  logic [16:0]       rounded;

  ffba_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_BLOCKS)) u_table (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(wr_addr),
    .wdata_i(wr_data),
    .re_i   (rd_en),
    .raddr_i(rd_addr),
    .rdata_o(rdata_raw)
  );

  assign rdata  = ffba_entry_t'(rdata_raw);
  assign more   = (iss_q < count_q);
  assign idle_o = (state_q == S_IDLE);
  assign done_o = (state_q == S_DONE);
  assign rem    = rdata.size - need_q[15:0];
  assign best_fin = (acc_q.free && (acc_q.size > best_q)) ? acc_q.size : best_q;
  assign rounded  = ({1'b0, req_i.request_bytes} + 17'(WORD_BYTES - 1))
                    & ~17'(WORD_BYTES - 1);

  always_comb begin
    res_o.status         = status_q;
    res_o.granted_offset = granted_q;
    res_o.largest_free   = largest_q;
    res_o.block_total    = 7'(count_q);
  end

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    pool_d    = pool_q;
    req_d     = req_q;
    iss_d     = iss_q;
    vld_d     = 1'b0;
    pidx_d    = pidx_q;
    wi_d      = wi_q;
    acc_d     = acc_q;
    acc_vld_d = acc_vld_q;
    best_d    = best_q;
    start_d   = start_q;
    need_d    = need_q;
    carry_d   = carry_q;
    shift_d   = shift_q;
    status_d  = status_q;
    granted_d = granted_q;
    largest_d = largest_q;
    rd_en     = 1'b0;
    rd_addr   = iss_q[AW-1:0];
    wr_en     = 1'b0;
    wr_addr   = pidx_q;
    wr_data   = rdata;

    // walking states issue one read a cycle while entries remain, data is seen in the next cycle
    if (state_q == S_MERGE || state_q == S_ALLOC || state_q == S_FREE) begin
      rd_en  = more;
      iss_d  = more ? iss_q + CW'(1) : iss_q;
      vld_d  = more;
      pidx_d = iss_q[AW-1:0];
    end

    case (state_q)
      S_INIT: begin
        wr_en     = 1'b1;
        wr_addr   = '0;
        wr_data.free = 1'b1;
        wr_data.size = (pool_q >= 16'(MGMT_BYTES)) ? pool_q - 16'(MGMT_BYTES) : '0;
        count_d   = CW'(1);
        if (cfg_we_i) begin
          // a further pool write restarts the initialisation
          pool_d  = cfg_wdata_i;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (cfg_we_i) begin
          pool_d  = cfg_wdata_i;
          state_d = S_INIT;
        end else if (start_i) begin
          req_d     = req_i;
          need_d    = rounded + 17'(HEADER_BYTES);
          status_d  = ST_OK;
          granted_d = '0;
          largest_d = '0;
          iss_d     = '0;
          wi_d      = '0;
          acc_vld_d = 1'b0;
          best_d    = '0;
          start_d   = 18'(MGMT_BYTES);
          shift_d   = 1'b0;
          case (req_i.req_type)
            REQ_ALLOC, REQ_QUERY: state_d = S_MERGE;
            REQ_FREE:             state_d = S_FREE;
            default:              state_d = S_DONE;
          endcase
        end
      end
      S_MERGE: begin
        if (vld_q) begin
          if (acc_vld_q && acc_q.free && rdata.free) begin
            acc_d.size = acc_q.size + rdata.size;
          end else begin
            if (acc_vld_q) begin
              wr_en   = 1'b1;
              wr_addr = wi_q[AW-1:0];
              wr_data = acc_q;
              best_d  = best_fin;
              wi_d    = wi_q + CW'(1);
            end
            acc_d = rdata;
          end
          acc_vld_d = 1'b1;
        end else if (!more) begin
          // flush the last run and settle the new block count
          wr_en     = 1'b1;
          wr_addr   = wi_q[AW-1:0];
          wr_data   = acc_q;
          count_d   = wi_q + CW'(1);
          iss_d     = '0;
          if (req_q.req_type == REQ_QUERY) begin
            largest_d = (best_fin > 16'(HEADER_BYTES)) ? best_fin - 16'(HEADER_BYTES) : '0;
            state_d   = S_DONE;
          end else begin
            state_d   = S_ALLOC;
          end
        end
      end
      S_ALLOC: begin
        if (vld_q) begin
          if (shift_q) begin
            // ripple later entries up by one to make room for the remainder
            wr_en   = 1'b1;
            wr_data = carry_q;
            carry_d = rdata;
          end else if (rdata.free && ({1'b0, rdata.size} >= need_q)) begin
            wr_en        = 1'b1;
            wr_data.free = 1'b0;
            granted_d    = 16'(start_q + 18'(HEADER_BYTES));
            if (rem >= 16'(HEADER_BYTES + WORD_BYTES) && count_q < CW'(MAX_BLOCKS)) begin
              wr_data.size = need_q[15:0];
              shift_d      = 1'b1;
              carry_d.free = 1'b1;
              carry_d.size = rem;
            end else begin
              state_d = S_DONE;
            end
          end else begin
            start_d = start_q + {2'b00, rdata.size};
          end
        end else if (!more) begin
          if (shift_q) begin
            wr_en   = 1'b1;
            wr_addr = count_q[AW-1:0];
            wr_data = carry_q;
            count_d = count_q + CW'(1);
          end else begin
            status_d = ST_NO_FIT;
          end
          state_d = S_DONE;
        end
      end
      S_FREE: begin
        if (vld_q) begin
          if (start_q + 18'(HEADER_BYTES) == {2'b00, req_q.payload_offset}) begin
            wr_en        = 1'b1;
            wr_data.free = 1'b1;
            state_d      = S_DONE;
          end else begin
            start_d = start_q + {2'b00, rdata.size};
          end
        end else if (!more) begin
          status_d = ST_NO_BLOCK;
          state_d  = S_DONE;
        end
      end
      S_DONE: begin
        if (ack_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_INIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_INIT;
      count_q   <= CW'(1);
      pool_q    <= 16'(POOL_RESET);
      iss_q     <= '0;
      vld_q     <= 1'b0;
      wi_q      <= '0;
      acc_vld_q <= 1'b0;
      shift_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      pool_q    <= pool_d;
      iss_q     <= iss_d;
      vld_q     <= vld_d;
      wi_q      <= wi_d;
      acc_vld_q <= acc_vld_d;
      shift_q   <= shift_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    pidx_q    <= pidx_d;
    acc_q     <= acc_d;
    best_q    <= best_d;
    start_q   <= start_d;
    need_q    <= need_d;
    carry_q   <= carry_d;
    status_q  <= status_d;
    granted_q <= granted_d;
    largest_q <= largest_d;
  end
endmodule

### rtl/core/first_fit_block_allocator.sv
// top level of the first-fit block allocator: handshakes and result register
// one item at a time, bounded by the single read port of the block table
// a new item is taken while the previous result still waits in the output register
// reset (asynchronous, active low) sets the pool to 4096 bytes; the init state then
// writes the table as one free block, as after every pool size write taken in idle
module first_fit_block_allocator (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [15:0]         cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ffba_pkg::ffba_in_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ffba_pkg::ffba_out_t out_item_o
);
  import ffba_pkg::*;

  logic      seq_idle, seq_done, ack, start;
  ffba_out_t seq_res;
  logic      out_vld_q, out_vld_d;
  ffba_out_t out_q;

  // only the walker's idle state takes a new item, a pool write goes first
  assign in_stall_o = !seq_idle || cfg_we_i;
  assign start      = in_valid_i && !in_stall_o;

  // a finished result moves on once the output register is free or draining
  assign ack = !out_vld_q || !out_stall_i;

  ffba_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .start_i    (start),
    .req_i      (in_item_i),
    .ack_i      (ack),
    .idle_o     (seq_idle),
    .done_o     (seq_done),
    .res_o      (seq_res)
  );

  always_comb begin
    out_vld_d = out_vld_q;
    if (ack) begin
      out_vld_d = seq_done;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  // output payload only changes when a new result is loaded
  always_ff @(posedge clk_i) begin
    if (ack && seq_done) begin
      out_q <= seq_res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;
endmodule

### rtl/core/ffba_checker.sv
// port-level checks of the first-fit block allocator and their binding
module ffba_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input ffba_pkg::ffba_out_t out_item_o
);
  import ffba_pkg::*;

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

  // failed alloc grants nothing
  a_nofit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status == ST_NO_FIT |-> out_item_o.granted_offset == 16'd0)
    else $error("no-fit result with nonzero offset");

  // table never empty
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.block_total != 7'd0)
    else $error("block count zero");

  // granted payload lies past management area and header
  a_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.granted_offset != 16'd0
      |-> out_item_o.granted_offset >= 16'(MGMT_BYTES + HEADER_BYTES))
    else $error("granted offset inside management area");
endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_item_o (out_item_o)
);

### tb/tb_first_fit_block_allocator.sv
// self-checking testbench of the first-fit block allocator with a model of the block table
module tb_first_fit_block_allocator;
  timeunit 1ns;
  timeprecision 1ps;
  import ffba_pkg::*;

  // clock, reset and block ports
  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  ffba_in_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  ffba_out_t out_item_o;

  first_fit_block_allocator dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_item_i(in_item_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_item_o(out_item_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // model of the block table, kept in step with accepted items
  logic [15:0] pool_size;
  logic [15:0] blk_size [MAX_BLOCKS];
  logic        blk_free [MAX_BLOCKS];
  int unsigned blk_count;

  ffba_out_t   result_queue [$];
  int          error_count = 0;
  bit          calm = 1'b0;     // when set neither side idles
  int unsigned quiet_cycles = 0;
  localparam int unsigned WATCHDOG = 20000;

  // rebuild the table as one free block after reset or a pool write
  task automatic table_clear();
    for (int k = 0; k < MAX_BLOCKS; k++) begin
      blk_size[k] = '0;
      blk_free[k] = 1'b0;
    end
    blk_size[0] = (pool_size >= MGMT_BYTES) ? pool_size - 16'(MGMT_BYTES) : '0;
    blk_free[0] = 1'b1;
    blk_count = 1;
  endtask

  // join runs of neighbouring free blocks
  task automatic coalesce();
    int unsigned i;
    i = 0;
    while (i + 1 < blk_count) begin
      if (blk_free[i] && blk_free[i+1]) begin
        blk_size[i] = blk_size[i] + blk_size[i+1];
        for (int unsigned k = i + 1; k + 1 < blk_count; k++) begin
          blk_size[k] = blk_size[k+1];
          blk_free[k] = blk_free[k+1];
        end
        blk_count--;
        blk_size[blk_count] = '0;
        blk_free[blk_count] = 1'b0;
      end else begin
        i++;
      end
    end
  endtask

  // work out the result of one request and update the table
  task automatic predict_request(input ffba_in_t req, output ffba_out_t res);
    int unsigned need, start, best, sz;
    bit hit;
    res = '0;
    hit = 1'b0;
    start = MGMT_BYTES;
    case (req.req_type)
      REQ_ALLOC: begin
        need = ((int'(req.request_bytes) + WORD_BYTES - 1) / WORD_BYTES) * WORD_BYTES
               + HEADER_BYTES;
        coalesce();
        for (int unsigned i = 0; i < blk_count && !hit; i++) begin
          sz = blk_size[i];
          if (blk_free[i] && sz >= need) begin
            blk_free[i] = 1'b0;
            if (sz - need >= HEADER_BYTES + WORD_BYTES && blk_count < MAX_BLOCKS) begin
              for (int unsigned k = blk_count; k > i + 1; k--) begin
                blk_size[k] = blk_size[k-1];
                blk_free[k] = blk_free[k-1];
              end
              blk_size[i] = 16'(need);
              blk_size[i+1] = 16'(sz - need);
              blk_free[i+1] = 1'b1;
              blk_count++;
            end
            res.granted_offset = 16'(start + HEADER_BYTES);
            hit = 1'b1;
          end else begin
            start += sz;
          end
        end
        if (!hit) res.status = ST_NO_FIT;
      end
      REQ_FREE: begin
        for (int unsigned i = 0; i < blk_count && !hit; i++) begin
          if (start + HEADER_BYTES == req.payload_offset) begin
            blk_free[i] = 1'b1;
            hit = 1'b1;
          end else begin
            start += blk_size[i];
          end
        end
        if (!hit) res.status = ST_NO_BLOCK;
      end
      REQ_QUERY: begin
        best = 0;
        coalesce();
        for (int unsigned i = 0; i < blk_count; i++)
          if (blk_free[i] && blk_size[i] > best) best = blk_size[i];
        res.largest_free = (best > HEADER_BYTES) ? 16'(best - HEADER_BYTES) : '0;
      end
      default: ;
    endcase
    res.block_total = 7'(blk_count);
  endtask

  // random payload offset of a live block, now and then off by 8 bytes, or an arbitrary value now and then
  function automatic logic [15:0] pick_offset();
    int unsigned idx, start;
    if ($urandom_range(0, 9) == 0) return 16'($urandom);
    idx = $urandom_range(0, blk_count - 1);
    start = MGMT_BYTES;
    for (int unsigned i = 0; i < idx; i++) start += blk_size[i];
    return 16'(start + HEADER_BYTES + (($urandom_range(0, 19) == 0) ? 8 : 0));
  endfunction

  // send one item and record what it should produce
  task automatic send_item(input logic [1:0] kind, input logic [15:0] bytes,
                           input logic [15:0] offset);
    ffba_in_t  req;
    ffba_out_t res;
    req.req_type = kind;
    req.request_bytes = bytes;
    req.payload_offset = offset;
    while (!calm && $urandom_range(0, 99) < 22) @(posedge clk_i);
    in_item_i  <= req;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_request(req, res);
    result_queue.push_back(res);
    in_valid_i <= 1'b0;
    // the block is still busy with this item anyway
    @(posedge clk_i);
  endtask

  // wait until every expected result is in, then let the block settle
  task automatic drain();
    while (result_queue.size() != 0) @(posedge clk_i);
    repeat (2 * MAX_BLOCKS + 20) @(posedge clk_i);
  endtask

  // pool size write while idle
  task automatic write_pool(input logic [15:0] bytes);
    drain();
    cfg_wdata_i <= bytes;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    pool_size = bytes;
    table_clear();
    repeat (2) @(posedge clk_i);
  endtask

  // directed items: field extremes, each request kind and the named corner cases
  task automatic test_directed();
    send_item(REQ_QUERY, 16'h0000, 16'h0000);
    send_item(REQ_ALLOC, 16'h0000, 16'h0000);   // zero bytes still takes a header
    send_item(REQ_ALLOC, 16'h0001, 16'hffff);   // rounds up to a word
    send_item(REQ_ALLOC, 16'hffff, 16'h0000);   // never fits
    send_item(REQ_FREE,  16'hffff, 16'h0028);   // first block freed
    send_item(REQ_FREE,  16'h0000, 16'h0028);   // already free
    send_item(REQ_FREE,  16'h0000, 16'hffff);   // unknown offset
    send_item(REQ_FREE,  16'h0000, 16'h0000);
    send_item(2'd3,      16'hffff, 16'hffff);   // unused request kind
    send_item(REQ_QUERY, 16'hffff, 16'hffff);   // merges before answering
    send_item(REQ_ALLOC, 16'd4040, 16'h0000);   // larger than the largest free block, no fit
    send_item(REQ_QUERY, 16'h0000, 16'h0000);   // largest free block after the failed alloc
    send_item(REQ_FREE,  16'h0000, 16'h0028);
    write_pool(16'd40);                         // pool with a block of 24 bytes
    send_item(REQ_ALLOC, 16'h0000, 16'h0000);
    send_item(REQ_QUERY, 16'h0000, 16'h0000);
    write_pool(16'd8);                          // pool below the management area
    send_item(REQ_ALLOC, 16'h0000, 16'h0000);
    send_item(REQ_QUERY, 16'h0000, 16'h0000);
    write_pool(16'hffff);
    send_item(REQ_ALLOC, 16'd65000, 16'h0000);
    send_item(REQ_QUERY, 16'h0000, 16'h0000);
  endtask

  // fill the table past its limit with small allocations
  task automatic test_full_table();
    write_pool(16'd4096);
    for (int i = 0; i < MAX_BLOCKS + 4; i++) send_item(REQ_ALLOC, 16'd8, 16'h0000);
    send_item(REQ_FREE, 16'h0000, 16'(MGMT_BYTES + HEADER_BYTES));
    send_item(REQ_ALLOC, 16'd1, 16'h0000);      // table full, taken unsplit
    send_item(REQ_QUERY, 16'h0000, 16'h0000);
  endtask

  // random alloc/free/query traffic, with some unused kinds, over several pool sizes
  task automatic test_random(input int unsigned count);
    logic [15:0] pools [5] = '{16'd4096, 16'd40, 16'd600, 16'd65535, 16'd1500};
    int unsigned r;
    for (int unsigned n = 0; n < count; n++) begin
      if (n % 340 == 0) write_pool((n == 680) ? 16'($urandom) : pools[n / 340]);
      calm = (n % 340 >= 150 && n % 340 < 220);
      r = $urandom_range(0, 99);
      if (r < 45)
        send_item(REQ_ALLOC, ($urandom_range(0, 19) == 0) ? 16'($urandom)
                                                          : 16'($urandom_range(0, 300)),
                  16'($urandom));
      else if (r < 85)
        send_item(REQ_FREE, 16'($urandom), pick_offset());
      else if (r < 97)
        send_item(REQ_QUERY, 16'($urandom), 16'($urandom));
      else
        send_item(2'd3, 16'($urandom), 16'($urandom));
    end
    calm = 1'b0;
  endtask

  // result checker with random stalls on the output side
  always @(posedge clk_i) begin
    ffba_out_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (result_queue.size() == 0) begin
          $error("result with nothing expected: %p", out_item_o);
          error_count++;
        end else begin
          want = result_queue.pop_front();
          if (out_item_o.status !== want.status) begin
            $error("status expected %0d actual %0d", want.status, out_item_o.status);
            error_count++;
          end
          if (out_item_o.granted_offset !== want.granted_offset) begin
            $error("granted_offset expected %0d actual %0d",
                   want.granted_offset, out_item_o.granted_offset);
            error_count++;
          end
          if (out_item_o.largest_free !== want.largest_free) begin
            $error("largest_free expected %0d actual %0d",
                   want.largest_free, out_item_o.largest_free);
            error_count++;
          end
          if (out_item_o.block_total !== want.block_total) begin
            $error("block_total expected %0d actual %0d",
                   want.block_total, out_item_o.block_total);
            error_count++;
          end
        end
      end
      out_stall_i <= !calm && ($urandom_range(0, 99) < 22);
    end
  end

  // watchdog on cycles without any accepted item, delivered result or pool write
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WATCHDOG) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    pool_size = 16'(POOL_RESET);
    table_clear();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_directed();
    test_full_table();
    test_random(1700);
    drain();
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
